// ===== design/camera_pixel_to_rgb_converter_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef CAMERA_PIXEL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define CAMERA_PIXEL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define CPRGB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cprgb assertion failed");

// Clocked assertion that is checked during reset as well.
`define CPRGB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cprgb assertion failed");

`endif

// ===== design/cprgb_pkg.sv =====
package cprgb_pkg;

    localparam logic [1:0] FMT_MONO8  = 2'd0;
    localparam logic [1:0] FMT_MONO16 = 2'd1;
    localparam logic [1:0] FMT_YUV422 = 2'd2;
    localparam logic [1:0] FMT_RGB24  = 2'd3;

    localparam int ACC_W = 25;
    localparam int FRAC_W = 14;

    localparam logic signed [15:0] K_RU = 16'sd15;
    localparam logic signed [15:0] K_RV = 16'sd22965;
    localparam logic signed [15:0] K_GU = 16'sd5631;
    localparam logic signed [15:0] K_GV = 16'sd11701;
    localparam logic signed [15:0] K_BU = 16'sd29035;
    localparam logic signed [15:0] K_BV = 16'sd16;
    localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       pixel_last;
        logic       frame_end_out;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic       is_yuv;
        logic [7:0] y;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       last;
        logic       fend;
    } t_pix;

    typedef struct packed {
        logic                    valid;
        logic                    is_yuv;
        logic signed [ACC_W-1:0] acc_r;
        logic signed [ACC_W-1:0] acc_g;
        logic signed [ACC_W-1:0] acc_b;
        logic [7:0]              c0;
        logic [7:0]              c1;
        logic [7:0]              c2;
        logic                    last;
        logic                    fend;
    } t_acc;

    function automatic logic [7:0] sat_q14(input logic signed [ACC_W-1:0] acc);
        logic [7:0] res;
        if (acc[ACC_W-1]) begin
            res = 8'd0;
        end else if (|acc[ACC_W-2:FRAC_W+8]) begin
            res = 8'hFF;
        end else begin
            res = acc[FRAC_W+7:FRAC_W];
        end
        return res;
    endfunction

endpackage

// ===== design/cprgb_split.sv =====
module cprgb_split
    import cprgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_in_item   i_in,
    input  logic [1:0] i_fmt,
    output logic       o_busy,
    output t_pix       o_pix
);

    logic       r_hold;
    logic [7:0] r_u;
    logic [7:0] r_v;
    logic [7:0] r_y1;
    logic       r_fend;
    logic       r_valid;
    t_pix       r_pix;
    t_pix       n_pix;
    logic       n_hold;
    logic       w_take;

    assign w_take = i_start && !r_hold;

    always_comb begin
        n_pix        = r_pix;
        n_pix.valid  = 1'b0;
        n_hold       = 1'b0;
        if (r_hold) begin
            n_pix.valid  = 1'b1;
            n_pix.is_yuv = 1'b1;
            n_pix.y      = r_y1;
            n_pix.c0     = r_u;
            n_pix.c1     = r_y1;
            n_pix.c2     = r_v;
            n_pix.last   = 1'b1;
            n_pix.fend   = r_fend;
        end else if (w_take) begin
            n_pix.valid = 1'b1;
            n_pix.y     = i_in.byte1;
            n_pix.last  = 1'b1;
            n_pix.fend  = i_in.frame_end;
            case (i_fmt)
                FMT_MONO8, FMT_MONO16: begin
                    n_pix.is_yuv = 1'b0;
                    n_pix.c0     = i_in.byte0;
                    n_pix.c1     = i_in.byte0;
                    n_pix.c2     = i_in.byte0;
                end
                FMT_YUV422: begin
                    n_pix.is_yuv = 1'b1;
                    n_pix.c0     = i_in.byte0;
                    n_pix.c1     = i_in.byte1;
                    n_pix.c2     = i_in.byte2;
                    n_pix.last   = 1'b0;
                    n_pix.fend   = 1'b0;
                    n_hold       = 1'b1;
                end
                default: begin
                    n_pix.is_yuv = 1'b0;
                    n_pix.c0     = i_in.byte0;
                    n_pix.c1     = i_in.byte1;
                    n_pix.c2     = i_in.byte2;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_hold  <= n_hold;
            r_valid <= n_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
        if (w_take) begin
            r_u    <= i_in.byte0;
            r_v    <= i_in.byte2;
            r_y1   <= i_in.byte3;
            r_fend <= i_in.frame_end;
        end
    end

    always_comb begin
        o_pix       = r_pix;
        o_pix.valid = r_valid;
    end

    assign o_busy = r_hold;

endmodule

// ===== design/cprgb_mac.sv =====
module cprgb_mac
    import cprgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_pix i_pix,
    output t_acc o_acc
);

    logic signed [8:0]       w_u;
    logic signed [8:0]       w_v;
    logic signed [ACC_W-1:0] r_p_ru;
    logic signed [ACC_W-1:0] r_p_rv;
    logic signed [ACC_W-1:0] r_p_gu;
    logic signed [ACC_W-1:0] r_p_gv;
    logic signed [ACC_W-1:0] r_p_bu;
    logic signed [ACC_W-1:0] r_p_bv;
    t_pix                    r_pix;
    logic                    r_pix_valid;
    logic signed [ACC_W-1:0] w_base;
    t_acc                    n_acc;
    t_acc                    r_acc;
    logic                    r_acc_valid;

    assign w_u = $signed({1'b0, i_pix.c0}) - CHROMA_OFS;
    assign w_v = $signed({1'b0, i_pix.c2}) - CHROMA_OFS;

    always_ff @(posedge i_clk) begin
        r_p_ru <= ACC_W'(w_u) * ACC_W'(K_RU);
        r_p_rv <= ACC_W'(w_v) * ACC_W'(K_RV);
        r_p_gu <= ACC_W'(w_u) * ACC_W'(K_GU);
        r_p_gv <= ACC_W'(w_v) * ACC_W'(K_GV);
        r_p_bu <= ACC_W'(w_u) * ACC_W'(K_BU);
        r_p_bv <= ACC_W'(w_v) * ACC_W'(K_BV);
        r_pix  <= i_pix;
    end

    assign w_base = $signed({3'b000, r_pix.y, {FRAC_W{1'b0}}});

    always_comb begin
        n_acc.valid  = r_pix_valid;
        n_acc.is_yuv = r_pix.is_yuv;
        n_acc.acc_r  = w_base - r_p_ru + r_p_rv;
        n_acc.acc_g  = w_base - r_p_gu - r_p_gv;
        n_acc.acc_b  = w_base + r_p_bu + r_p_bv;
        n_acc.c0     = r_pix.c0;
        n_acc.c1     = r_pix.c1;
        n_acc.c2     = r_pix.c2;
        n_acc.last   = r_pix.last;
        n_acc.fend   = r_pix.fend;
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
            r_acc_valid <= 1'b0;
        end else begin
            r_pix_valid <= i_pix.valid;
            r_acc_valid <= r_pix_valid;
        end
    end

    always_comb begin
        o_acc       = r_acc;
        o_acc.valid = r_acc_valid;
    end

endmodule

// ===== design/cprgb_sat.sv =====
module cprgb_sat
    import cprgb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_acc      i_acc,
    output logic      o_valid,
    output t_out_item o_out
);

    t_out_item r_out;
    t_out_item n_out;
    logic      r_valid;

    always_comb begin
        if (i_acc.is_yuv) begin
            n_out.red   = sat_q14(i_acc.acc_r);
            n_out.green = sat_q14(i_acc.acc_g);
            n_out.blue  = sat_q14(i_acc.acc_b);
        end else begin
            n_out.red   = i_acc.c0;
            n_out.green = i_acc.c1;
            n_out.blue  = i_acc.c2;
        end
        n_out.pixel_last    = i_acc.last;
        n_out.frame_end_out = i_acc.fend;
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_acc.valid;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// ===== design/camera_pixel_to_rgb_converter_core.sv =====
// An item's first pixel passes the split output register, the mac product and accumulator
// registers and the saturation register before it is on the result ports.
// Throughput: one pixel per cycle; mono and rgb24 items enter every cycle, a yuv422
// item holds busy high for a single cycle while its second pixel enters the pipeline.
// The receiver cannot stall; the pipeline never holds back.
// Synchronous active-low reset clears the format register to mono8 and empties the pipeline.
module camera_pixel_to_rgb_converter_core
    import cprgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic [1:0] r_fmt;
    t_pix       w_pix;
    t_acc       w_acc;

    assign o_cfg_ready = !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_MONO8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fmt <= i_cfg_data;
        end
    end

    cprgb_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .i_fmt   (r_fmt),
        .o_busy  (o_busy),
        .o_pix   (w_pix)
    );

    cprgb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (w_pix),
        .o_acc   (w_acc)
    );

    cprgb_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .o_valid (o_out_valid),
        .o_out   (o_out)
    );

endmodule

// ===== design/cprgb_checker.sv =====
`include "camera_pixel_to_rgb_converter_core_defines.svh"

module cprgb_checker
    import cprgb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input logic      o_out_valid,
    input t_out_item o_out
);

    `CPRGB_ASSERT(a_busy_one_cycle, i_clk, i_rst_n, o_busy |=> !o_busy)
    `CPRGB_ASSERT(a_busy_after_take, i_clk, i_rst_n, o_busy |-> $past(i_start && !o_busy))
    `CPRGB_ASSERT(a_take_gives_pixel, i_clk, i_rst_n, (i_start && !o_busy) |-> ##4 o_out_valid)
    `CPRGB_ASSERT(a_first_then_last, i_clk, i_rst_n, (o_out_valid && !o_out.pixel_last) |=> (o_out_valid && o_out.pixel_last))
    `CPRGB_ASSERT_ALWAYS(a_fend_on_last, i_clk, (o_out_valid && o_out.frame_end_out) |-> o_out.pixel_last)

endmodule

bind camera_pixel_to_rgb_converter_core cprgb_checker u_cprgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_out_valid (o_out_valid),
    .o_out       (o_out)
);

// ===== sim/camera_pixel_to_rgb_converter_core_test.sv =====
`timescale 1ns / 100ps

module camera_pixel_to_rgb_converter_core_test;
    import cprgb_pkg::*;

    localparam int Q14_ONE = 16384;
    localparam int COEF_RED_U = 15;
    localparam int COEF_RED_V = 22965;
    localparam int COEF_GREEN_U = 5631;
    localparam int COEF_GREEN_V = 11701;
    localparam int COEF_BLUE_U = 29035;
    localparam int COEF_BLUE_V = 16;
    localparam int CHROMA_MID = 128;
    localparam int PIPE_SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 125;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in_item   i_in;
    logic       o_out_valid;
    t_out_item  o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data;

    t_out_item  pending_pixels[$];
    logic [1:0] active_format;
    logic       idling_enabled;
    int         error_count;
    int         quiet_cycles;

    camera_pixel_to_rgb_converter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] clamp_q14(int acc);
        int whole;
        whole = acc / Q14_ONE;
        if (whole < 0) begin
            return 8'd0;
        end
        if (whole > 255) begin
            return 8'd255;
        end
        return whole[7:0];
    endfunction

    function automatic t_out_item yuv_to_rgb(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr,
                                             logic last, logic fend);
        t_out_item pix;
        int y_q;
        int u;
        int v;
        y_q = int'(luma);
        y_q = y_q * Q14_ONE;
        u = int'(cb);
        u = u - CHROMA_MID;
        v = int'(cr);
        v = v - CHROMA_MID;
        pix.red = clamp_q14(y_q - COEF_RED_U * u + COEF_RED_V * v);
        pix.green = clamp_q14(y_q - COEF_GREEN_U * u - COEF_GREEN_V * v);
        pix.blue = clamp_q14(y_q + COEF_BLUE_U * u + COEF_BLUE_V * v);
        pix.pixel_last = last;
        pix.frame_end_out = fend;
        return pix;
    endfunction

    function automatic void predict_pixels(t_in_item it);
        t_out_item pix;
        case (active_format)
            FMT_MONO8, FMT_MONO16: begin
                pix.red = it.byte0;
                pix.green = it.byte0;
                pix.blue = it.byte0;
                pix.pixel_last = 1'b1;
                pix.frame_end_out = it.frame_end;
                pending_pixels.push_back(pix);
            end
            FMT_YUV422: begin
                pending_pixels.push_back(yuv_to_rgb(it.byte1, it.byte0, it.byte2, 1'b0, 1'b0));
                pending_pixels.push_back(yuv_to_rgb(it.byte3, it.byte0, it.byte2, 1'b1,
                                                    it.frame_end));
            end
            default: begin
                pix.red = it.byte0;
                pix.green = it.byte1;
                pix.blue = it.byte2;
                pix.pixel_last = 1'b1;
                pix.frame_end_out = it.frame_end;
                pending_pixels.push_back(pix);
            end
        endcase
    endfunction

    function automatic t_in_item make_item(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                           logic [7:0] b3, logic fend);
        t_in_item it;
        it.byte0 = b0;
        it.byte1 = b1;
        it.byte2 = b2;
        it.byte3 = b3;
        it.frame_end = fend;
        return it;
    endfunction

    function automatic t_in_item random_item();
        return make_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 7) == 0));
    endfunction

    task automatic send_item(t_in_item it);
        i_start <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_busy);
        predict_pixels(it);
    endtask

    task automatic idle_burst();
        if (idling_enabled && ($urandom_range(0, 3) == 0)) begin
            i_start <= 1'b0;
            i_in <= random_item();
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_pixel_format(logic [1:0] fmt);
        wait_drained();
        repeat (PIPE_SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= fmt;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 2'($urandom_range(0, 3));
        active_format = fmt;
    endtask

    // The format register is expected to come out of reset as mono8.
    task automatic test_mono8();
        send_item(make_item(8'd0, 8'd255, 8'd255, 8'd255, 1'b0));
        set_pixel_format(FMT_MONO8);
        send_item(make_item(8'd255, 8'd0, 8'd0, 8'd0, 1'b1));
        send_item(make_item(8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0));
        wait_drained();
    endtask

    task automatic test_mono16();
        set_pixel_format(FMT_MONO16);
        send_item(make_item(8'd0, 8'd255, 8'd0, 8'd255, 1'b1));
        send_item(make_item(8'd255, 8'd0, 8'd255, 8'd0, 1'b0));
        send_item(make_item(8'h81, 8'h7E, 8'h12, 8'h34, 1'b1));
        wait_drained();
    endtask

    task automatic test_yuv422();
        set_pixel_format(FMT_YUV422);
        send_item(make_item(8'd128, 8'd0, 8'd128, 8'd255, 1'b0));
        send_item(make_item(8'd0, 8'd0, 8'd0, 8'd255, 1'b1));
        send_item(make_item(8'd255, 8'd255, 8'd255, 8'd0, 1'b0));
        send_item(make_item(8'd0, 8'd128, 8'd255, 8'd128, 1'b1));
        send_item(make_item(8'd255, 8'd128, 8'd0, 8'd128, 1'b0));
        send_item(make_item(8'd128, 8'd16, 8'd128, 8'd235, 1'b1));
        send_item(make_item(8'd100, 8'd200, 8'd150, 8'd50, 1'b0));
        send_item(make_item(8'd255, 8'd0, 8'd0, 8'd255, 1'b1));
        send_item(make_item(8'd0, 8'd255, 8'd255, 8'd0, 1'b0));
        send_item(make_item(8'd129, 8'd1, 8'd127, 8'd254, 1'b1));
        wait_drained();
    endtask

    task automatic test_rgb24();
        set_pixel_format(FMT_RGB24);
        send_item(make_item(8'd0, 8'd255, 8'd0, 8'd255, 1'b0));
        send_item(make_item(8'd255, 8'd0, 8'd255, 8'd0, 1'b1));
        send_item(make_item(8'h12, 8'h34, 8'h56, 8'h78, 1'b0));
        wait_drained();
    endtask

    task automatic test_random_stream();
        logic [1:0] fmt;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                fmt = FMT_RGB24;
            end else if (phase == RANDOM_PHASES - 1) begin
                fmt = FMT_MONO8;
            end else if (phase == 2) begin
                fmt = FMT_YUV422;
            end else begin
                fmt = 2'($urandom_range(0, 3));
            end
            idling_enabled = (phase != RANDOM_PHASES - 1);
            set_pixel_format(fmt);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(random_item());
                if ((phase == 3) && (n == ITEMS_PER_PHASE / 2)) begin
                    wait_drained();
                end else begin
                    idle_burst();
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel with no transfer pending: %p", o_out);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_out.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_out.red);
                    error_count++;
                end
                if (o_out.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_out.green);
                    error_count++;
                end
                if (o_out.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_out.blue);
                    error_count++;
                end
                if (o_out.pixel_last !== want.pixel_last) begin
                    $error("pixel_last: expected %0d, got %0d", want.pixel_last,
                           o_out.pixel_last);
                    error_count++;
                end
                if (o_out.frame_end_out !== want.frame_end_out) begin
                    $error("frame_end_out: expected %0d, got %0d", want.frame_end_out,
                           o_out.frame_end_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_out_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        error_count = 0;
        quiet_cycles = 0;
        active_format = FMT_MONO8;
        idling_enabled = 1'b1;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mono8();
        test_mono16();
        test_yuv422();
        test_rgb24();
        test_random_stream();

        wait_drained();
        repeat (PIPE_SETTLE_CYCLES * 2) @(posedge i_clk);
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/cprgb_pkg.sv
design/cprgb_split.sv
design/cprgb_mac.sv
design/cprgb_sat.sv
design/camera_pixel_to_rgb_converter_core.sv
design/cprgb_checker.sv
sim/camera_pixel_to_rgb_converter_core_test.sv
